FILE: src/mtsg_pkg.sv
// Package for the multitone sine generator: register indexes, reset values,
// field widths and the elaboration-time cosine table functions.
// No dependencies.
package mtsg_pkg;

  localparam int REG_TONES   = 3;
  localparam int STEP_W      = 32;
  localparam int OFFSET_W    = 16;
  localparam int GAIN_W      = 8;
  localparam int GAINS_W     = GAIN_W * REG_TONES;
  localparam int DC_W        = 8;
  localparam int SAMPLE_W    = 26;
  localparam int INDEX_W     = 32;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam int DEF_PHASE_BITS       = 32;
  localparam int DEF_TABLE_ADDR_BITS  = 10;
  localparam int DEF_OUTPUT_FRAC_BITS = 15;
  localparam int DEF_TONE_COUNT       = 3;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_1  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_2  = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP_3  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET_1 = 4'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET_2 = 4'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_OFFSET_3 = 4'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_TONE_GAINS    = 4'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_DC_LEVEL      = 4'd7;

  localparam logic [STEP_W-1:0]   RST_PHASE_STEP_1   = 32'd429496730;
  localparam logic [STEP_W-1:0]   RST_PHASE_STEP_2   = 32'd572662306;
  localparam logic [STEP_W-1:0]   RST_PHASE_STEP_3   = 32'd858993459;
  localparam logic [OFFSET_W-1:0] RST_PHASE_OFFSET_1 = 16'd58982;
  localparam logic [OFFSET_W-1:0] RST_PHASE_OFFSET_2 = 16'd49152;
  localparam logic [OFFSET_W-1:0] RST_PHASE_OFFSET_3 = 16'd54613;
  localparam logic [GAINS_W-1:0]  RST_TONE_GAINS     = 24'h040304;
  localparam logic signed [DC_W-1:0] RST_DC_LEVEL    = 8'sd2;

  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  // (a * b) >> 62 from 32-bit partial products
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] hh, hl, lh, ll, mid, hi, lo;
    hh  = {32'd0, a[63:32]} * {32'd0, b[63:32]};
    hl  = {32'd0, a[63:32]} * {32'd0, b[31:0]};
    lh  = {32'd0, a[31:0]} * {32'd0, b[63:32]};
    ll  = {32'd0, a[31:0]} * {32'd0, b[31:0]};
    mid = {32'd0, ll[63:32]} + {32'd0, hl[31:0]} + {32'd0, lh[31:0]};
    hi  = hh + {32'd0, hl[63:32]} + {32'd0, lh[63:32]} + {32'd0, mid[63:32]};
    lo  = {mid[31:0], ll[31:0]};
    return {hi[61:0], lo[63:62]};
  endfunction

  // Taylor term divisors n*(n+1): cosine odd n from 1, sine even n from 2
  function automatic logic [63:0] series_div(input logic [63:0] t, input logic [3:0] step,
                                             input logic odd);
    logic [63:0] q;
    case ({odd, step})
      5'h00: q = t / 64'd2;
      5'h01: q = t / 64'd12;
      5'h02: q = t / 64'd30;
      5'h03: q = t / 64'd56;
      5'h04: q = t / 64'd90;
      5'h05: q = t / 64'd132;
      5'h06: q = t / 64'd182;
      5'h07: q = t / 64'd240;
      5'h08: q = t / 64'd306;
      5'h09: q = t / 64'd380;
      5'h0a: q = t / 64'd462;
      5'h0b: q = t / 64'd552;
      5'h10: q = t / 64'd6;
      5'h11: q = t / 64'd20;
      5'h12: q = t / 64'd42;
      5'h13: q = t / 64'd72;
      5'h14: q = t / 64'd110;
      5'h15: q = t / 64'd156;
      5'h16: q = t / 64'd210;
      5'h17: q = t / 64'd272;
      5'h18: q = t / 64'd342;
      5'h19: q = t / 64'd420;
      5'h1a: q = t / 64'd506;
      5'h1b: q = t / 64'd600;
      default: q = 64'd0;
    endcase
    return q;
  endfunction

  // sine (odd) or cosine series in Q62 for x in [0, pi/4]
  function automatic logic [63:0] series_q62(input logic [63:0] x, input logic odd);
    logic [63:0] x2, term, sum;
    x2   = mul_q62(x, x);
    term = odd ? x : ONE_Q62;
    sum  = term;
    for (int i = 0; i < 12; i++) begin
      term = series_div(mul_q62(term, x2), 4'(i), odd);
      if (i % 2 == 1) sum = sum + term;
      else sum = sum - term;
    end
    return sum;
  endfunction

  // magnitude of one quarter-wave table entry, rounded half away from zero
  function automatic logic [63:0] cos_mag(input int unsigned r, input logic use_sin,
                                          input int unsigned qbits, input int unsigned fbits);
    logic [63:0] x, c, amp, mask;
    mask = (64'd1 << qbits) - 64'd1;
    x    = (HALF_PI_Q62 >> qbits) * 64'(r) + (((HALF_PI_Q62 & mask) * 64'(r)) >> qbits);
    c    = series_q62(x, use_sin);
    if (c > ONE_Q62) c = ONE_Q62;
    amp  = (64'd1 << fbits) - 64'd1;
    return (((c >> 30) * amp) + (64'd1 << 31)) >> 32;
  endfunction

endpackage

FILE: src/multitone_sine_generator_unit.sv
// Multitone sine generator top level: phase accumulators, cosine lookup and sample sum.
// Depends on mtsg_pkg.
//
// Each tick transfer yields one sample, dc_level scaled to OUTPUT_FRAC_BITS fraction
// bits plus up to three gain-weighted cosines, with its sample index. One tick is taken
// every cycle while tick_stall is low; the phase accumulators are a single add per tick
// and set that rate. A result passes through the address, table and sum registers, the
// first loaded at the transfer edge. While a finished sample waits on sample_stall, the
// address and table stages take up to two more ticks; after that tick_stall follows
// sample_stall until the sample is transferred. The quarter-wave cosine table is a
// constant built at elaboration, so there is no fill or clearing time after reset.
// Write configuration only while no sample is in flight.
module multitone_sine_generator_unit
  import mtsg_pkg::*;
#(
  parameter int PHASE_BITS       = DEF_PHASE_BITS,
  parameter int TABLE_ADDR_BITS  = DEF_TABLE_ADDR_BITS,
  parameter int OUTPUT_FRAC_BITS = DEF_OUTPUT_FRAC_BITS,
  parameter int TONE_COUNT       = DEF_TONE_COUNT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       tick_valid,
  output logic                       tick_stall,
  input  logic                       restart,
  output logic                       sample_valid,
  input  logic                       sample_stall,
  output logic signed [SAMPLE_W-1:0] sample_value,
  output logic [INDEX_W-1:0]         sample_index
);

  localparam int ACT_TONES = (TONE_COUNT < REG_TONES) ? TONE_COUNT : REG_TONES;
  localparam int AW        = TABLE_ADDR_BITS;
  localparam int QW        = TABLE_ADDR_BITS - 2;
  localparam int QUARTER   = 1 << QW;
  localparam int HALF      = QUARTER / 2;
  localparam int MW        = OUTPUT_FRAC_BITS;
  localparam int TW        = OUTPUT_FRAC_BITS + 1;
  localparam logic [MW-1:0] SIN_MID = MW'(cos_mag(HALF, 1'b1, QW, OUTPUT_FRAC_BITS));

  // configuration
  logic [STEP_W-1:0]        phase_step   [REG_TONES];
  logic [OFFSET_W-1:0]      phase_offset [REG_TONES];
  logic [GAINS_W-1:0]       tone_gains;
  logic signed [DC_W-1:0]   dc_level;

  // state
  logic [PHASE_BITS-1:0]    tone_phase   [REG_TONES];
  logic [PHASE_BITS-1:0]    tone_phase_next [REG_TONES];
  logic [INDEX_W-1:0]       sample_counter;
  logic [INDEX_W-1:0]       index_now;

  // pipeline
  logic                     v1, v2;
  logic [AW-1:0]            addr1 [ACT_TONES];
  logic [AW-1:0]            addr_next [ACT_TONES];
  logic [INDEX_W-1:0]       idx1, idx2;
  logic signed [TW-1:0]     tval2 [ACT_TONES];
  logic signed [TW-1:0]     tval_next [ACT_TONES];
  logic signed [SAMPLE_W-1:0] sample_value_next;
  logic                     rdy1, rdy2, rdy3, accept;

  logic [MW-1:0]            qtab [QUARTER];

  for (genvar g = 0; g < QUARTER; g++) begin : g_qtab
    if (g > HALF) begin : g_sin
      assign qtab[g] = MW'(cos_mag(QUARTER - g, 1'b1, QW, OUTPUT_FRAC_BITS));
    end else begin : g_cos
      assign qtab[g] = MW'(cos_mag(g, 1'b0, QW, OUTPUT_FRAC_BITS));
    end
  end

  assign cfg_ready  = 1'b1;
  assign rdy3       = !sample_valid || !sample_stall;
  assign rdy2       = !v2 || rdy3;
  assign rdy1       = !v1 || rdy2;
  assign tick_stall = !rdy1;
  assign accept     = tick_valid && rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step[0]   <= RST_PHASE_STEP_1;
      phase_step[1]   <= RST_PHASE_STEP_2;
      phase_step[2]   <= RST_PHASE_STEP_3;
      phase_offset[0] <= RST_PHASE_OFFSET_1;
      phase_offset[1] <= RST_PHASE_OFFSET_2;
      phase_offset[2] <= RST_PHASE_OFFSET_3;
      tone_gains      <= RST_TONE_GAINS;
      dc_level        <= RST_DC_LEVEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PHASE_STEP_1:   phase_step[0]   <= cfg_data;
        REG_PHASE_STEP_2:   phase_step[1]   <= cfg_data;
        REG_PHASE_STEP_3:   phase_step[2]   <= cfg_data;
        REG_PHASE_OFFSET_1: phase_offset[0] <= cfg_data[OFFSET_W-1:0];
        REG_PHASE_OFFSET_2: phase_offset[1] <= cfg_data[OFFSET_W-1:0];
        REG_PHASE_OFFSET_3: phase_offset[2] <= cfg_data[OFFSET_W-1:0];
        REG_TONE_GAINS:     tone_gains      <= cfg_data[GAINS_W-1:0];
        REG_DC_LEVEL:       dc_level        <= cfg_data[DC_W-1:0];
        default: ;
      endcase
    end
  end

  // phase update and lookup address; restart zeroes phase and index first
  always_comb begin
    logic [PHASE_BITS-1:0]        ph;
    logic [STEP_W+PHASE_BITS-1:0] step_wide;
    logic [OFFSET_W+PHASE_BITS-1:0] off_wide;
    logic [PHASE_BITS-1:0]        sum;
    index_now = restart ? '0 : sample_counter;
    for (int k = 0; k < REG_TONES; k++) begin
      ph        = restart ? '0 : tone_phase[k];
      step_wide = {phase_step[k], {PHASE_BITS{1'b0}}};
      tone_phase_next[k] = ph + step_wide[STEP_W+PHASE_BITS-1:STEP_W];
      if (k < ACT_TONES) begin
        off_wide = {phase_offset[k], {PHASE_BITS{1'b0}}};
        sum      = ph + off_wide[OFFSET_W+PHASE_BITS-1:OFFSET_W];
        addr_next[k] = sum[PHASE_BITS-1 -: AW];
      end
    end
  end

  // quarter-wave lookup with sign
  always_comb begin
    logic [1:0]    q;
    logic [QW-1:0] r;
    logic [MW-1:0] m;
    for (int k = 0; k < ACT_TONES; k++) begin
      q = addr1[k][AW-1 -: 2];
      r = addr1[k][QW-1:0];
      if (!q[0]) m = qtab[r];
      else if (r == '0) m = '0;
      else if (r == QW'(HALF)) m = SIN_MID;
      else m = qtab[QW'(QUARTER - int'(r))];
      tval_next[k] = (q[1] ^ q[0]) ? -$signed({1'b0, m}) : $signed({1'b0, m});
    end
  end

  // dc plus weighted tones, kept modulo the sample width
  always_comb begin
    logic signed [SAMPLE_W-1:0] gain;
    sample_value_next = SAMPLE_W'(dc_level) <<< OUTPUT_FRAC_BITS;
    for (int k = 0; k < ACT_TONES; k++) begin
      gain = SAMPLE_W'($signed({1'b0, tone_gains[GAIN_W*k +: GAIN_W]}));
      sample_value_next = sample_value_next + gain * SAMPLE_W'(tval2[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      for (int k = 0; k < REG_TONES; k++) tone_phase[k] <= '0;
    end else if (accept) begin
      sample_counter <= index_now + 1'b1;
      for (int k = 0; k < REG_TONES; k++) tone_phase[k] <= tone_phase_next[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      sample_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= accept;
      if (rdy2) v2 <= v1;
      if (rdy3) sample_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx1  <= index_now;
      addr1 <= addr_next;
    end
    if (rdy2) begin
      idx2  <= idx1;
      tval2 <= tval_next;
    end
    if (rdy3) begin
      sample_index <= idx2;
      sample_value <= sample_value_next;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    tick_stall |-> (v1 && v2 && sample_valid && sample_stall))
    else $error("tick stalled with a free stage");

  a_restart_index: assert property (@(posedge clk) disable iff (rst)
    (accept && restart) |=> (idx1 == '0))
    else $error("restart did not zero the sample index");

  a_counter_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> (sample_counter == idx1 + 1'b1))
    else $error("sample counter out of step with issued index");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(sample_valid) |-> $past(v2))
    else $error("result without a sample in the table stage");

endmodule
